[rtl/dqp_pkg.sv]
package dqp_pkg;

  // Packet geometry
  localparam int MAX_PACKET_BYTES = 512;
  localparam int HEADER_BYTES     = 12;
  localparam int MIN_PACKET_BYTES = 17;
  localparam int TAIL_BYTES       = 4;

  // Byte position counter saturates at its all-ones value
  localparam int          POS_W     = 10;
  localparam int          LEN_W     = POS_W + 1;
  localparam logic [POS_W-1:0] POS_LIMIT = '1;

  localparam logic [7:0] DOT_CHAR = 8'h2E;

  // Result queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_LABEL,
    PH_TYPE_HI,
    PH_TYPE_LO,
    PH_TAIL
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  name_char;
    logic [15:0] query_type;
    logic        query_valid;
    logic        last;
  } dqp_result_t;

  // Which of the two result slots a transaction fills
  typedef struct packed {
    logic char_vld;
    logic sum_vld;
  } dqp_push_t;

endpackage

[rtl/dqp_parser.sv]
module dqp_parser import dqp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  packet_byte,
  input  logic        end_of_packet,
  output dqp_push_t   push,
  output dqp_result_t char_res,
  output dqp_result_t sum_res
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  phase_t           phase_r, phase_nxt;
  logic [7:0]       left_r, left_nxt;
  logic             started_r, started_nxt;
  logic [POS_W-1:0] name_end_r, name_end_nxt;
  logic [7:0]       type_hi_r, type_hi_nxt;
  logic [7:0]       type_lo_r, type_lo_nxt;
  logic             too_long_r, too_long_nxt;

  // Values after this byte's update, before the end-of-packet clear
  phase_t           phase_upd;
  logic [7:0]       left_upd;
  logic             started_upd;
  logic [POS_W-1:0] name_end_upd;
  logic [7:0]       type_hi_upd;
  logic [7:0]       type_lo_upd;
  logic             too_long_upd;
  logic             char_emit;
  logic [7:0]       char_val;

  logic             in_range;
  logic [LEN_W-1:0] len;
  logic [7:0]       left_dec;
  logic             len_ok;
  logic             phase_ok;
  logic             tail_ok;
  logic             pkt_ok;

  assign in_range = {1'b0, pos_r} < LEN_W'(MAX_PACKET_BYTES);
  assign len      = {1'b0, pos_r} + LEN_W'(1);
  assign left_dec = left_r - 8'd1;

  // Next state: walk header, labels and type bytes
  always_comb begin
    phase_upd    = phase_r;
    left_upd     = left_r;
    started_upd  = started_r;
    name_end_upd = name_end_r;
    type_hi_upd  = type_hi_r;
    type_lo_upd  = type_lo_r;
    too_long_upd = too_long_r |
                   ({1'b0, pos_r} >= LEN_W'(MAX_PACKET_BYTES - 1));
    char_emit    = 1'b0;
    char_val     = 8'h00;
    if (in_range) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (pos_r >= POS_W'(HEADER_BYTES - 1)) phase_upd = PH_LENGTH;
        end
        PH_LENGTH: begin
          if (packet_byte == 8'h00) begin
            name_end_upd = (pos_r == POS_LIMIT) ? POS_LIMIT : pos_r + POS_W'(1);
            phase_upd    = PH_TYPE_HI;
          end else begin
            char_emit   = started_r;
            char_val    = DOT_CHAR;
            started_upd = 1'b1;
            left_upd    = packet_byte;
            phase_upd   = PH_LABEL;
          end
        end
        PH_LABEL: begin
          char_emit = 1'b1;
          char_val  = packet_byte;
          left_upd  = left_dec;
          if (left_dec == 8'h00) phase_upd = PH_LENGTH;
        end
        PH_TYPE_HI: begin
          type_hi_upd = packet_byte;
          phase_upd   = PH_TYPE_LO;
        end
        PH_TYPE_LO: begin
          type_lo_upd = packet_byte;
          phase_upd   = PH_TAIL;
        end
        default: begin
        end
      endcase
    end
  end

  // Summary checks on the updated state
  assign len_ok   = (len >= LEN_W'(MIN_PACKET_BYTES)) && (len < LEN_W'(MAX_PACKET_BYTES));
  assign phase_ok = (phase_upd == PH_TYPE_HI) || (phase_upd == PH_TYPE_LO) ||
                    (phase_upd == PH_TAIL);
  assign tail_ok  = ({2'b00, name_end_upd} + (LEN_W + 1)'(TAIL_BYTES)) <= {1'b0, len};
  assign pkt_ok   = !too_long_upd && len_ok && phase_ok && tail_ok;

  // Register updates: clear everything after the closing byte
  always_comb begin
    pos_nxt = (pos_r == POS_LIMIT) ? pos_r : pos_r + POS_W'(1);
    if (end_of_packet) begin
      pos_nxt      = '0;
      phase_nxt    = PH_HEADER;
      left_nxt     = '0;
      started_nxt  = 1'b0;
      name_end_nxt = '0;
      type_hi_nxt  = '0;
      type_lo_nxt  = '0;
      too_long_nxt = 1'b0;
    end else begin
      phase_nxt    = phase_upd;
      left_nxt     = left_upd;
      started_nxt  = started_upd;
      name_end_nxt = name_end_upd;
      type_hi_nxt  = type_hi_upd;
      type_lo_nxt  = type_lo_upd;
      too_long_nxt = too_long_upd;
    end
  end

  // Result outputs
  always_comb begin
    push.char_vld         = accept && char_emit;
    push.sum_vld          = accept && end_of_packet;
    char_res              = '0;
    char_res.name_char    = char_val;
    sum_res               = '0;
    sum_res.kind          = 1'b1;
    sum_res.query_valid   = pkt_ok;
    sum_res.last          = 1'b1;
    sum_res.query_type    = pkt_ok ? {type_hi_upd, type_lo_upd} : 16'h0000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      phase_r    <= PH_HEADER;
      left_r     <= '0;
      started_r  <= 1'b0;
      name_end_r <= '0;
      type_hi_r  <= '0;
      type_lo_r  <= '0;
      too_long_r <= 1'b0;
    end else if (accept) begin
      pos_r      <= pos_nxt;
      phase_r    <= phase_nxt;
      left_r     <= left_nxt;
      started_r  <= started_nxt;
      name_end_r <= name_end_nxt;
      type_hi_r  <= type_hi_nxt;
      type_lo_r  <= type_lo_nxt;
      too_long_r <= too_long_nxt;
    end
  end

endmodule

[rtl/dqp_out_fifo.sv]
module dqp_out_fifo import dqp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dqp_push_t         push,
  input  dqp_result_t       char_res,
  input  dqp_result_t       sum_res,
  input  logic              pop,
  output logic              not_empty,
  output logic              room_for_two,
  output logic [QCNT_W-1:0] level,
  output dqp_result_t       head
);

  dqp_result_t       mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [QPTR_W-1:0] sum_addr;
  logic              do_pop;

  assign not_empty    = cnt_r != '0;
  assign room_for_two = cnt_r <= QCNT_W'(QDEPTH - 2);
  assign level        = cnt_r;
  assign head         = mem[rd_ptr_r];
  assign do_pop       = pop && not_empty;

  // Summary lands after the character when both arrive together
  assign sum_addr = push.char_vld ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.char_vld) + QPTR_W'(push.sum_vld);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(do_pop);
    cnt_nxt    = cnt_r + QCNT_W'(push.char_vld) + QCNT_W'(push.sum_vld) -
                 QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push.char_vld) mem[wr_ptr_r] <= char_res;
    if (push.sum_vld)  mem[sum_addr] <= sum_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[rtl/dns_question_parser.sv]
// Results are written into a result queue and show on out_ in order from its head.
// Throughput: one byte per cycle while in_stall is low; a byte yields at most two results
//   (character and summary), held in a four-entry result queue; in_stall rises while it holds three or more.
// Reset: synchronous, active low; clears the parse state and empties the result queue.
// The parse state returns to its reset value after every end-of-packet byte.
module dns_question_parser import dqp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_packet_byte,
  input  logic        in_end_of_packet,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_name_char,
  output logic [15:0] out_query_type,
  output logic        out_query_valid,
  output logic        out_last
);

  logic              in_accept;
  logic              room_for_two;
  logic [QCNT_W-1:0] q_level;
  dqp_push_t         push;
  dqp_result_t       char_res;
  dqp_result_t       sum_res;
  dqp_result_t       head;

  // Take a transaction only when the queue can absorb two results
  assign in_stall  = !room_for_two;
  assign in_accept = in_valid && !in_stall;

  dqp_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_accept),
    .packet_byte   (in_packet_byte),
    .end_of_packet (in_end_of_packet),
    .push          (push),
    .char_res      (char_res),
    .sum_res       (sum_res)
  );

  dqp_out_fifo u_out_fifo (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .char_res     (char_res),
    .sum_res      (sum_res),
    .pop          (!out_stall),
    .not_empty    (out_valid),
    .room_for_two (room_for_two),
    .level        (q_level),
    .head         (head)
  );

  assign out_kind        = head.kind;
  assign out_name_char   = head.name_char;
  assign out_query_type  = head.query_type;
  assign out_query_valid = head.query_valid;
  assign out_last        = head.last;

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_eop_summary: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_end_of_packet |=> out_valid)
    else $error("no result queued after end of packet");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result queue not empty after reset");
`endif

endmodule
